// File: design/assert_macros.svh
// Assertion macros shared by the soft rate dematcher RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LSRD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("lsrd: property violated");
`define LSRD_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("lsrd: forbidden condition seen");
`else
`define LSRD_ASSERT(label, prop)
`define LSRD_NEVER(label, cond)
`endif
`endif

// File: design/lsrd_pkg.sv
// Shared types, codes and layout table of the soft rate dematcher
package lsrd_pkg;

    localparam int POS_W       = 11;
    localparam int LEN_CODE_W  = 5;
    localparam int KNOWN_W     = 11;
    localparam int ACTION_W    = 2;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 11;

    localparam logic [ACTION_W-1:0] ACT_START  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SYMBOL = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_CODE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KNOWN_VALUE = 4'd1;

    localparam logic [LEN_CODE_W-1:0] LENGTH_CODE_RESET = 5'd0;
    localparam logic [KNOWN_W-1:0]    KNOWN_VALUE_RESET = 11'd40;  // 10.0 in Q9.2

    // one past the highest code bit position any length code produces
    localparam logic [POS_W-1:0] POS_LIMIT = 11'd1088;

    typedef logic [POS_W-1:0] t_pos;

    typedef struct packed {
        t_pos msg_start;
        t_pos msg_end;
        t_pos par_start;
        t_pos par_end;
        t_pos frame_bits;
        t_pos code_bits;
    } t_layout;

    // one accepted beat, handed from the pointer unit to the store pipeline
    typedef struct packed {
        logic valid;
        logic start;
        logic wr;
        logic rd;
        logic last;
        t_pos pos;
    } t_issue;

    function automatic t_layout derive_layout(input logic [LEN_CODE_W-1:0] code);
        t_layout    l;
        logic [1:0] base;
        logic [2:0] tail;
        logic [4:0] tail_bytes;
        logic [6:0] msg_bytes;
        base       = code[4:3] & 2'h3;
        tail       = code[2:0] & 3'h7;
        tail_bytes = 5'd1 + 5'd3 * {2'b00, tail};
        msg_bytes  = 7'd22 * {5'b00000, base} + {2'b00, tail_bytes};
        l.msg_end  = {1'b0, msg_bytes, 3'b000};
        case (base)
            2'd0: begin
                l.msg_start  = (tail_bytes <= 5'd13) ? 11'd0 : 11'd16;
                l.code_bits  = 11'd272;
                l.par_start  = 11'd176;
                l.par_end    = 11'd272;
                l.frame_bits = 11'd256;
            end
            2'd1: begin
                l.msg_start  = 11'd32;
                l.code_bits  = 11'd544;
                l.par_start  = 11'd352;
                l.par_end    = 11'd544;
                l.frame_bits = 11'd512;
            end
            2'd2: begin
                l.msg_start  = 11'd64;
                l.code_bits  = 11'd1088;
                l.par_start  = 11'd704;
                l.par_end    = 11'd992;
                l.frame_bits = 11'd768;
            end
            default: begin
                l.msg_start  = 11'd64;
                l.code_bits  = 11'd1088;
                l.par_start  = 11'd704;
                l.par_end    = 11'd1088;
                l.frame_bits = 11'd1024;
            end
        endcase
        return l;
    endfunction

endpackage

// File: design/lsrd_store.sv
// Soft value store: one write port, one read port with registered read data
module lsrd_store #(
    parameter int DEPTH = 1088,
    parameter int WIDTH = 12,
    parameter int AW    = 11
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/lsrd_ptr.sv
// Position sequencer: message, parity and readout pointers per accepted beat
`include "assert_macros.svh"
module lsrd_ptr (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [lsrd_pkg::ACTION_W-1:0] i_action,
    input  lsrd_pkg::t_layout             i_layout,
    input  lsrd_pkg::t_pos                i_code_len,
    output lsrd_pkg::t_issue              o_issue
);

    import lsrd_pkg::*;

    t_pos r_msg_ptr;
    t_pos r_par_ptr;
    logic r_in_msg;
    t_pos r_taken;
    t_pos r_rd_ptr;

    t_pos n_msg_ptr;
    t_pos n_par_ptr;
    logic n_in_msg;
    t_pos n_taken;
    t_pos n_rd_ptr;

    t_pos rd_idx;
    logic rd_last;

    always_comb begin
        n_msg_ptr = r_msg_ptr;
        n_par_ptr = r_par_ptr;
        n_in_msg  = r_in_msg;
        n_taken   = r_taken;
        n_rd_ptr  = r_rd_ptr;
        o_issue   = '0;
        o_issue.valid = i_accept;
        rd_idx    = (r_rd_ptr >= i_code_len) ? '0 : r_rd_ptr;
        rd_last   = (rd_idx == i_code_len - 1'b1);
        if (i_accept) begin
            case (i_action)
                ACT_START: begin
                    o_issue.start = 1'b1;
                    n_msg_ptr = i_layout.msg_start;
                    n_par_ptr = i_layout.par_start;
                    n_in_msg  = 1'b1;
                    n_taken   = '0;
                    n_rd_ptr  = '0;
                end
                ACT_SYMBOL: begin
                    if (r_taken < i_layout.frame_bits) begin
                        o_issue.wr = 1'b1;
                        n_taken    = r_taken + 1'b1;
                        if (r_in_msg) begin
                            o_issue.pos = r_msg_ptr;
                            if (r_msg_ptr >= i_layout.msg_end - 1'b1) begin
                                n_msg_ptr = i_layout.msg_start;
                                n_in_msg  = 1'b0;
                            end else begin
                                n_msg_ptr = r_msg_ptr + 1'b1;
                            end
                        end else begin
                            o_issue.pos = r_par_ptr;
                            if (r_par_ptr >= i_layout.par_end - 1'b1) begin
                                n_par_ptr = i_layout.par_start;
                                n_in_msg  = 1'b1;
                            end else begin
                                n_par_ptr = r_par_ptr + 1'b1;
                            end
                        end
                    end
                end
                ACT_READ: begin
                    o_issue.rd   = 1'b1;
                    o_issue.pos  = rd_idx;
                    o_issue.last = rd_last;
                    n_rd_ptr     = rd_last ? '0 : rd_idx + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_ptr <= '0;
            r_par_ptr <= '0;
            r_in_msg  <= 1'b1;
            r_taken   <= '0;
            r_rd_ptr  <= '0;
        end else begin
            r_msg_ptr <= n_msg_ptr;
            r_par_ptr <= n_par_ptr;
            r_in_msg  <= n_in_msg;
            r_taken   <= n_taken;
            r_rd_ptr  <= n_rd_ptr;
        end
    end

    `LSRD_NEVER(a_rd_in_range, o_issue.valid && o_issue.rd && (o_issue.pos >= i_code_len))
    `LSRD_NEVER(a_ptr_bound, (r_msg_ptr >= POS_LIMIT) || (r_par_ptr >= POS_LIMIT))

endmodule

// File: design/lsrd_rmw.sv
// Store pipeline: read-modify-write with forwarding, clearing sweep, output register
`include "assert_macros.svh"
module lsrd_rmw #(
    parameter int DEPTH        = 1088,
    parameter int AW           = 11,
    parameter int SYMBOL_WIDTH = 8,
    parameter int SOFT_WIDTH   = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lsrd_pkg::t_issue               i_issue,
    input  logic signed [SYMBOL_WIDTH-1:0] i_symbol,
    input  lsrd_pkg::t_pos                 i_fill_lo,
    input  lsrd_pkg::t_pos                 i_fill_hi,
    input  logic [SOFT_WIDTH-1:0]          i_fill_val,
    output logic                           o_busy,
    output logic                           o_mem_wr_en,
    output logic [AW-1:0]                  o_mem_wr_addr,
    output logic [SOFT_WIDTH-1:0]          o_mem_wr_data,
    output logic                           o_mem_rd_en,
    output logic [AW-1:0]                  o_mem_rd_addr,
    input  logic [SOFT_WIDTH-1:0]          i_mem_rd_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SOFT_WIDTH-1:0]   o_soft_value,
    output lsrd_pkg::t_pos                 o_bit_index,
    output logic                           o_last
);

    import lsrd_pkg::*;

    localparam int SumW = ((SOFT_WIDTH > SYMBOL_WIDTH) ? SOFT_WIDTH : SYMBOL_WIDTH) + 1;
    localparam int DepW = $clog2(DEPTH + 1);
    localparam int CmpW = (DepW > POS_W) ? DepW : POS_W;
    localparam logic [CmpW-1:0] DepthC = CmpW'(DEPTH);
    localparam logic [AW-1:0]   SwLast = AW'(DEPTH - 1);
    localparam logic signed [SumW-1:0] SumMax = SumW'((1 << (SOFT_WIDTH - 1)) - 1);
    localparam logic signed [SumW-1:0] SumMin = SumW'(-(1 << (SOFT_WIDTH - 1)));
    localparam logic [SOFT_WIDTH-1:0]  SoftMax = {1'b0, {(SOFT_WIDTH - 1){1'b1}}};
    localparam logic [SOFT_WIDTH-1:0]  SoftMin = {1'b1, {(SOFT_WIDTH - 1){1'b0}}};

    t_issue                         r_s1;
    logic signed [SYMBOL_WIDTH-1:0] r_sym;
    logic                           r_sweep;
    logic [AW-1:0]                  r_sw_cnt;
    t_pos                           r_fill_lo;
    t_pos                           r_fill_hi;
    logic [SOFT_WIDTH-1:0]          r_fill_val;
    logic                           r_fw_valid;
    logic [AW-1:0]                  r_fw_addr;
    logic [SOFT_WIDTH-1:0]          r_fw_data;
    logic                           r_out_valid;
    logic signed [SOFT_WIDTH-1:0]   r_out_soft;
    t_pos                           r_out_idx;
    logic                           r_out_last;

    t_issue                       s1_next;
    logic                         stall;
    logic                         s1_wr_en;
    logic                         out_load;
    logic [AW-1:0]                s1_addr;
    logic [SOFT_WIDTH-1:0]        old_val;
    logic signed [SumW-1:0]       ext_old;
    logic signed [SumW-1:0]       ext_sym;
    logic signed [SumW-1:0]       sum;
    logic [SOFT_WIDTH-1:0]        sat_sum;
    logic [CmpW-1:0]              sw_pos;
    logic                         sw_fill;

    assign s1_addr  = AW'(r_s1.pos);
    assign old_val  = (r_fw_valid && (r_fw_addr == s1_addr)) ? r_fw_data : i_mem_rd_data;
    assign ext_old  = {{(SumW - SOFT_WIDTH){old_val[SOFT_WIDTH-1]}}, old_val};
    assign ext_sym  = {{(SumW - SYMBOL_WIDTH){r_sym[SYMBOL_WIDTH-1]}}, r_sym};
    assign sum      = ext_old + ext_sym;

    always_comb begin
        if (sum > SumMax) begin
            sat_sum = SoftMax;
        end else if (sum < SumMin) begin
            sat_sum = SoftMin;
        end else begin
            sat_sum = sum[SOFT_WIDTH-1:0];
        end
    end

    always_comb begin
        s1_next       = i_issue;
        s1_next.valid = i_issue.valid && (i_issue.wr || i_issue.rd);
    end

    assign stall    = r_s1.valid && r_s1.rd && r_out_valid && !i_out_ready;
    assign out_load = r_s1.valid && r_s1.rd && !stall;
    assign s1_wr_en = r_s1.valid && r_s1.wr && (CmpW'(r_s1.pos) < DepthC);
    assign o_busy   = r_sweep || stall;

    assign sw_pos  = CmpW'(r_sw_cnt);
    assign sw_fill = (sw_pos >= CmpW'(r_fill_lo)) && (sw_pos < CmpW'(r_fill_hi));

    assign o_mem_wr_en   = r_sweep || s1_wr_en;
    assign o_mem_wr_addr = r_sweep ? r_sw_cnt : s1_addr;
    assign o_mem_wr_data = r_sweep ? (sw_fill ? r_fill_val : '0) : sat_sum;
    assign o_mem_rd_en   = i_issue.valid && (i_issue.wr || i_issue.rd);
    assign o_mem_rd_addr = AW'(i_issue.pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_sweep     <= 1'b0;
            r_sw_cnt    <= '0;
            r_fw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!stall) begin
                r_s1 <= s1_next;
            end
            if (i_issue.valid && i_issue.start) begin
                r_sweep  <= 1'b1;
                r_sw_cnt <= '0;
            end else if (r_sweep) begin
                if (r_sw_cnt == SwLast) begin
                    r_sweep <= 1'b0;
                end
                r_sw_cnt <= r_sw_cnt + 1'b1;
            end
            if (o_mem_wr_en) begin
                r_fw_valid <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_sym <= i_symbol;
        end
        if (i_issue.valid && i_issue.start) begin
            r_fill_lo  <= i_fill_lo;
            r_fill_hi  <= i_fill_hi;
            r_fill_val <= i_fill_val;
        end
        if (o_mem_wr_en) begin
            r_fw_addr <= o_mem_wr_addr;
            r_fw_data <= o_mem_wr_data;
        end
        if (out_load) begin
            r_out_soft <= old_val;
            r_out_idx  <= r_s1.pos;
            r_out_last <= r_s1.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_soft_value = r_out_soft;
    assign o_bit_index  = r_out_idx;
    assign o_last       = r_out_last;

    `LSRD_NEVER(a_port_clash, r_sweep && s1_wr_en)
    `LSRD_NEVER(a_issue_in_sweep, r_sweep && i_issue.valid)
    `LSRD_ASSERT(a_sweep_runs, r_sweep && (r_sw_cnt != SwLast) |=> r_sweep)

endmodule

// File: design/ldpc_soft_rate_dematcher.sv
// Top level of the LDPC soft rate dematcher with repetition combining
//
// Channel   Handshake                 Beat contents
// input     i_in_valid / o_in_ready   i_action, i_symbol
// output    o_out_valid / i_out_ready o_soft_value, o_bit_index, o_last
// config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Symbol and read beats: one per cycle while o_in_ready is high, set by one store
// read-modify-write per cycle with the last write forwarded. An accepted read beat is
// registered in the stage register, then its result in the output register. A start beat
// runs a clearing sweep over every store address, input not ready meanwhile. Reset clears
// pointers and config; store contents are undefined until the first start. A read beat
// waiting on a full, untaken output register holds o_in_ready low.
module ldpc_soft_rate_dematcher #(
    parameter int MAX_CODE_BITS = 1088,
    parameter int SYMBOL_WIDTH  = 8,
    parameter int SOFT_WIDTH    = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [lsrd_pkg::ACTION_W-1:0]    i_action,
    input  logic signed [SYMBOL_WIDTH-1:0]   i_symbol,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [SOFT_WIDTH-1:0]     o_soft_value,
    output logic [lsrd_pkg::POS_W-1:0]       o_bit_index,
    output logic                             o_last,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lsrd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [lsrd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import lsrd_pkg::*;

    localparam int AW       = (MAX_CODE_BITS > 1) ? $clog2(MAX_CODE_BITS) : 1;
    localparam int KvCmpW   = (SOFT_WIDTH > KNOWN_W) ? SOFT_WIDTH : KNOWN_W;
    localparam logic [KvCmpW-1:0]     KvMax   = KvCmpW'((1 << (SOFT_WIDTH - 1)) - 1);
    localparam logic [SOFT_WIDTH-1:0] SoftMax = {1'b0, {(SOFT_WIDTH - 1){1'b1}}};

    logic [LEN_CODE_W-1:0] r_length_code;
    logic [KNOWN_W-1:0]    r_known;

    t_layout               layout;
    t_pos                  code_len;
    logic [SOFT_WIDTH-1:0] kv_sat;
    logic                  in_accept;
    logic                  busy;
    t_issue                issue;

    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    logic [SOFT_WIDTH-1:0] mem_wr_data;
    logic                  mem_rd_en;
    logic [AW-1:0]         mem_rd_addr;
    logic [SOFT_WIDTH-1:0] mem_rd_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_code <= LENGTH_CODE_RESET;
            r_known       <= KNOWN_VALUE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LENGTH_CODE: r_length_code <= i_cfg_data[LEN_CODE_W-1:0];
                CFG_KNOWN_VALUE: r_known       <= i_cfg_data[KNOWN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign layout   = derive_layout(r_length_code);
    assign code_len = (int'(layout.code_bits) < MAX_CODE_BITS) ? layout.code_bits
                                                                : POS_W'(MAX_CODE_BITS);
    assign kv_sat   = (KvCmpW'(r_known) > KvMax) ? SoftMax : SOFT_WIDTH'(r_known);

    assign o_in_ready = !busy;
    assign in_accept  = i_in_valid && o_in_ready;

    lsrd_ptr u_ptr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_action   (i_action),
        .i_layout   (layout),
        .i_code_len (code_len),
        .o_issue    (issue)
    );

    lsrd_rmw #(
        .DEPTH        (MAX_CODE_BITS),
        .AW           (AW),
        .SYMBOL_WIDTH (SYMBOL_WIDTH),
        .SOFT_WIDTH   (SOFT_WIDTH)
    ) u_rmw (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_issue       (issue),
        .i_symbol      (i_symbol),
        .i_fill_lo     (layout.msg_end),
        .i_fill_hi     (layout.par_start),
        .i_fill_val    (kv_sat),
        .o_busy        (busy),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data),
        .o_mem_rd_en   (mem_rd_en),
        .o_mem_rd_addr (mem_rd_addr),
        .i_mem_rd_data (mem_rd_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_soft_value  (o_soft_value),
        .o_bit_index   (o_bit_index),
        .o_last        (o_last)
    );

    lsrd_store #(
        .DEPTH (MAX_CODE_BITS),
        .WIDTH (SOFT_WIDTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

endmodule
